/* hdl/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types, constants and helper functions for the character statistics
// block.
// ----------------------------------------------------------------------------
package chs_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int STAT_W      = 32;
	localparam int IDX_W       = 6;

	localparam int NUM_CLASSES = 4;
	localparam int NUM_ALPHA   = 26;
	localparam int HIST_DEPTH  = 2 * NUM_ALPHA;
	localparam int HIST_AW     = $clog2(HIST_DEPTH);

	// report order
	localparam int STAT_LINES    = 4;
	localparam int STAT_LONGEST  = 5;
	localparam int STAT_SHORTEST = 6;
	localparam int HIST_BASE     = 7;
	localparam int NUM_STATS     = HIST_BASE + HIST_DEPTH;
	localparam int LAST_STAT     = NUM_STATS - 1;

	localparam logic CMD_TEXT = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_DIGIT_0 = 8'h30;
	localparam logic [7:0] CH_DIGIT_9 = 8'h39;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	typedef enum logic [1:0] {
		CLS_UPPER,
		CLS_LOWER,
		CLS_DIGIT,
		CLS_OTHER
	} class_t;

	typedef struct packed {
		count_t [NUM_CLASSES-1:0] class_cnt;
		count_t                   lines;
		count_t                   longest;
		count_t                   shortest;
	} cnt_stats_t;

	typedef struct packed {
		logic               busy;
		logic               rd_en;
		logic [HIST_AW-1:0] rd_addr;
		logic               clear;
	} rpt_ctrl_t;

	function automatic count_t sat_inc(input count_t v);
		return (v == '1) ? v : v + count_t'(1);
	endfunction

	function automatic class_t classify(input logic [7:0] b);
		class_t c;
		if (b >= CH_UPPER_A && b <= CH_UPPER_Z)
			c = CLS_UPPER;
		else if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
			c = CLS_LOWER;
		else if (b >= CH_DIGIT_0 && b <= CH_DIGIT_9)
			c = CLS_DIGIT;
		else
			c = CLS_OTHER;
		return c;
	endfunction

	// bin number: capitals first, then lowercase
	function automatic logic [HIST_AW-1:0] letter_index(input logic [7:0] b);
		logic [7:0] off;
		if (b <= CH_UPPER_Z)
			off = b - CH_UPPER_A;
		else
			off = b - CH_LOWER_A + 8'(NUM_ALPHA);
		return HIST_AW'(off);
	endfunction

	localparam int EXT_W = (COUNT_WIDTH > STAT_W) ? COUNT_WIDTH : STAT_W;

	// report values clamp to the output width
	function automatic logic [STAT_W-1:0] clamp_stat(input count_t v);
		logic [EXT_W-1:0] ext;
		ext = EXT_W'(v);
		if ((ext >> STAT_W) != '0)
			return '1;
		return STAT_W'(ext);
	endfunction

endpackage

/* hdl/chs_hist_ram.sv */
// ----------------------------------------------------------------------------
// chs_hist_ram
// Letter histogram storage: one write port, one registered read port, and a
// valid bit per bin so an unwritten or cleared bin reads as zero.
// ----------------------------------------------------------------------------
module chs_hist_ram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [chs_pkg::HIST_AW-1:0] rd_addr,
	output chs_pkg::count_t             rd_data,
	input  logic                        wr_en,
	input  logic [chs_pkg::HIST_AW-1:0] wr_addr,
	input  chs_pkg::count_t             wr_data,
	input  logic                        clear
);

	chs_pkg::count_t                    mem [chs_pkg::HIST_DEPTH];
	logic [chs_pkg::HIST_DEPTH-1:0]     valid_q;
	chs_pkg::count_t                    rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (clear) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* hdl/chs_counters.sv */
// ----------------------------------------------------------------------------
// chs_counters
// Class counters and line length tracking, all saturating.
// ----------------------------------------------------------------------------
module chs_counters (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_acc,
	input  logic [7:0]          text_byte,
	input  logic                end_acc,
	input  logic                clear,
	output chs_pkg::cnt_stats_t stats
);

	chs_pkg::count_t [chs_pkg::NUM_CLASSES-1:0] class_q;
	chs_pkg::count_t newline_q;
	chs_pkg::count_t cur_len_q;
	chs_pkg::count_t longest_q;
	chs_pkg::count_t shortest_q;
	chs_pkg::class_t cls;
	logic            is_nl;

	assign cls   = chs_pkg::classify(text_byte);
	assign is_nl = (text_byte == chs_pkg::CH_NEWLINE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q    <= '0;
			newline_q  <= '0;
			cur_len_q  <= '0;
			longest_q  <= '0;
			shortest_q <= '1;
		end else if (clear) begin
			class_q    <= '0;
			newline_q  <= '0;
			cur_len_q  <= '0;
			longest_q  <= '0;
			shortest_q <= '1;
		end else if (byte_acc) begin
			for (int i = 0; i < chs_pkg::NUM_CLASSES; i++) begin
				if (cls == chs_pkg::class_t'(i))
					class_q[i] <= chs_pkg::sat_inc(class_q[i]);
			end
			if (is_nl) begin
				newline_q <= chs_pkg::sat_inc(newline_q);
				if (cur_len_q > longest_q)
					longest_q <= cur_len_q;
				if (cur_len_q < shortest_q)
					shortest_q <= cur_len_q;
				cur_len_q <= '0;
			end else begin
				cur_len_q <= chs_pkg::sat_inc(cur_len_q);
			end
		end else if (end_acc) begin
			// close the last line, possibly empty
			if (cur_len_q > longest_q)
				longest_q <= cur_len_q;
			if (cur_len_q < shortest_q)
				shortest_q <= cur_len_q;
			cur_len_q <= '0;
		end
	end

	assign stats.class_cnt = class_q;
	assign stats.lines     = chs_pkg::sat_inc(newline_q);
	assign stats.longest   = longest_q;
	assign stats.shortest  = shortest_q;

endmodule

/* hdl/chs_report.sv */
// ----------------------------------------------------------------------------
// chs_report
// Report sequencer: walks the statistics in order, fetches histogram bins,
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module chs_report (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  chs_pkg::cnt_stats_t              stats,
	input  chs_pkg::count_t                  hist_data,
	output chs_pkg::rpt_ctrl_t               ctrl,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [chs_pkg::IDX_W-1:0]        stat_index,
	output logic [chs_pkg::STAT_W-1:0]       stat_value,
	output logic                             last_stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t                       state_q;
	logic [chs_pkg::IDX_W-1:0]    k_q;
	logic                         out_valid_q;
	logic [chs_pkg::IDX_W-1:0]    idx_q;
	logic [chs_pkg::STAT_W-1:0]   value_q;
	logic                         last_q;
	logic                         take;
	logic                         load;
	logic                         at_last;
	chs_pkg::count_t              sel;

	assign take    = !out_valid_q || !out_stall;
	assign load    = (state_q == ST_LOAD) && take;
	assign at_last = (k_q == chs_pkg::IDX_W'(chs_pkg::LAST_STAT));

	always_comb begin
		priority if (k_q < chs_pkg::IDX_W'(chs_pkg::NUM_CLASSES))
			sel = stats.class_cnt[k_q[1:0]];
		else if (k_q == chs_pkg::IDX_W'(chs_pkg::STAT_LINES))
			sel = stats.lines;
		else if (k_q == chs_pkg::IDX_W'(chs_pkg::STAT_LONGEST))
			sel = stats.longest;
		else if (k_q == chs_pkg::IDX_W'(chs_pkg::STAT_SHORTEST))
			sel = stats.shortest;
		else
			sel = hist_data;
	end

	assign ctrl.busy    = (state_q != ST_IDLE);
	assign ctrl.rd_en   = (state_q == ST_READ) && (k_q >= chs_pkg::IDX_W'(chs_pkg::HIST_BASE));
	assign ctrl.rd_addr = chs_pkg::HIST_AW'(k_q - chs_pkg::IDX_W'(chs_pkg::HIST_BASE));
	assign ctrl.clear   = (state_q == ST_LOAD) && take && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			value_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			// a new load refills the register, else a taken result empties it
			out_valid_q <= load || (out_valid_q && out_stall);
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						k_q     <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (take) begin
						idx_q       <= k_q;
						value_q     <= chs_pkg::clamp_stat(sel);
						last_q      <= at_last;
						if (at_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + chs_pkg::IDX_W'(1);
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign stat_index = idx_q;
	assign stat_value = value_q;
	assign last_stat  = last_q;

endmodule

/* hdl/text_character_statistics.sv */
// ----------------------------------------------------------------------------
// text_character_statistics
// Counts character classes, lines and letters of a byte stream and reports
// 59 statistics on an end-of-text request.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  input    | in        | in_valid/in_stall  | command, text_byte
//  output   | out       | out_valid/out_stall| stat_index, stat_value, last_stat
//
//  Cycles: one text byte request per cycle, back to back, while in_stall is
//  low. An end-of-text request starts a report of 59 results, each through a
//  read state (a bin read from the histogram memory, for the bins) and then a
//  load into the output register. The block stays busy, with in_stall high,
//  until the last load, and longer under any output stall.
//  Reset: asynchronous, active low; bin valid bits clear at once, no sweep.
//  Stalls: out_stall holds the current result; the sequencer waits for it.
module text_character_statistics (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic [7:0]                       text_byte,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [chs_pkg::IDX_W-1:0]        stat_index,
	output logic [chs_pkg::STAT_W-1:0]       stat_value,
	output logic                             last_stat
);

	logic                          in_acc;
	logic                          byte_acc;
	logic                          end_acc;
	logic                          is_letter;
	logic [chs_pkg::HIST_AW-1:0]   letter_idx;
	chs_pkg::class_t               cls;

	// read-modify-write stage for the letter bin
	logic                          upd_valid_s1;
	logic [chs_pkg::HIST_AW-1:0]   upd_idx_s1;
	chs_pkg::count_t               bin_old;
	chs_pkg::count_t               bin_new;

	// last write, forwarded to a back-to-back hit on the same bin
	logic                          fwd_valid_q;
	logic [chs_pkg::HIST_AW-1:0]   fwd_idx_q;
	chs_pkg::count_t               fwd_val_q;

	logic                          ram_rd_en;
	logic [chs_pkg::HIST_AW-1:0]   ram_rd_addr;
	chs_pkg::count_t               ram_rd_data;

	chs_pkg::cnt_stats_t           stats;
	chs_pkg::rpt_ctrl_t            ctrl;

	assign in_stall = ctrl.busy;
	assign in_acc   = in_valid && !in_stall;
	assign byte_acc = in_acc && (command == chs_pkg::CMD_TEXT);
	assign end_acc  = in_acc && (command == chs_pkg::CMD_END);

	assign cls        = chs_pkg::classify(text_byte);
	assign is_letter  = (cls == chs_pkg::CLS_UPPER) || (cls == chs_pkg::CLS_LOWER);
	assign letter_idx = chs_pkg::letter_index(text_byte);

	// the report only reads while no byte can be accepted
	assign ram_rd_en   = ctrl.rd_en || (byte_acc && is_letter);
	assign ram_rd_addr = ctrl.rd_en ? ctrl.rd_addr : letter_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			upd_valid_s1 <= 1'b0;
		else
			upd_valid_s1 <= byte_acc && is_letter;
	end

	always_ff @(posedge clk) begin
		if (byte_acc && is_letter)
			upd_idx_s1 <= letter_idx;
	end

	assign bin_old = (fwd_valid_q && (fwd_idx_q == upd_idx_s1)) ? fwd_val_q : ram_rd_data;
	assign bin_new = chs_pkg::sat_inc(bin_old);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			fwd_valid_q <= 1'b0;
		end else if (upd_valid_s1) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_valid_s1) begin
			fwd_idx_q <= upd_idx_s1;
			fwd_val_q <= bin_new;
		end
	end

	chs_hist_ram u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data),
		.wr_en   (upd_valid_s1),
		.wr_addr (upd_idx_s1),
		.wr_data (bin_new),
		.clear   (ctrl.clear)
	);

	chs_counters u_cnt (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_acc  (byte_acc),
		.text_byte (text_byte),
		.end_acc   (end_acc),
		.clear     (ctrl.clear),
		.stats     (stats)
	);

	chs_report u_rpt (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (end_acc),
		.stats      (stats),
		.hist_data  (ram_rd_data),
		.ctrl       (ctrl),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.stat_index (stat_index),
		.stat_value (stat_value),
		.last_stat  (last_stat)
	);

	// a pending bin write must never meet the end-of-report clear
	a_no_clear_during_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.clear && upd_valid_s1))
		else $error("histogram clear overlaps a bin update");

	// an end-of-text request always starts the report
	a_end_starts_report: assert property (@(posedge clk) disable iff (!arst_n)
		end_acc |=> in_stall)
		else $error("report did not start after end of text");

	// the marked result is the final statistic
	a_last_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_stat) |-> (stat_index == chs_pkg::IDX_W'(chs_pkg::LAST_STAT)))
		else $error("last_stat on a result other than the final one");

	// no report histogram read while a bin update is in flight
	a_no_read_during_update: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.rd_en && upd_valid_s1))
		else $error("report read overlaps a bin update");

endmodule
